// ----- sv/bsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfe_pkg: shared types and constants of the byte stuffing frame encoder
// Item and result structs, opcodes, framing bytes and the job record that
// travels from the front classifier to the back byte sequencer.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  localparam int unsigned MaxBytes = 3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command;
    logic [7:0] device_id;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Line bytes of one item; last_idx is the index of its final byte.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               last_idx;
  } job_t;

  function automatic logic needs_escape(input logic [7:0] value);
    return (value == FLAG_BYTE) || (value == ESC_BYTE);
  endfunction

endpackage

// ----- sv/bsfe_front.sv -----
// ----------------------------------------------------------------------------
// bsfe_front: item classifier and check accumulator
// Turns each accepted item into a job of up to three line bytes and keeps the
// running XOR of the bytes sent since the last start item.
// ----------------------------------------------------------------------------
module bsfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  bsfe_pkg::in_item_t item,
  output logic              job_valid,
  output bsfe_pkg::job_t    job
);
  import bsfe_pkg::*;

  logic [7:0] check_acc;
  logic [7:0] check_acc_next;
  logic [7:0] header;
  logic [7:0] check;

  assign header = item.command | item.device_id;
  assign check  = ~check_acc & BYTE_MASK;

  always_comb begin
    job            = '0;
    job_valid      = 1'b0;
    check_acc_next = check_acc;
    unique case (item.opcode)
      OP_START: begin
        job_valid      = 1'b1;
        job.bytes[0]   = FLAG_BYTE;
        job.bytes[1]   = header;
        job.last_idx   = 2'd1;
        check_acc_next = header;
      end
      OP_DATA: begin
        job_valid = 1'b1;
        if (needs_escape(item.data_byte)) begin
          job.bytes[0]   = ESC_BYTE;
          job.bytes[1]   = item.data_byte ^ ESC_XOR;
          job.last_idx   = 2'd1;
          check_acc_next = check_acc ^ ESC_BYTE ^ (item.data_byte ^ ESC_XOR);
        end else begin
          job.bytes[0]   = item.data_byte;
          job.last_idx   = 2'd0;
          check_acc_next = check_acc ^ item.data_byte;
        end
      end
      OP_END: begin
        job_valid = 1'b1;
        // check byte is not folded back into the accumulator
        if (needs_escape(check)) begin
          job.bytes[0] = ESC_BYTE;
          job.bytes[1] = check ^ ESC_XOR;
          job.bytes[2] = FLAG_BYTE;
          job.last_idx = 2'd2;
        end else begin
          job.bytes[0] = check;
          job.bytes[1] = FLAG_BYTE;
          job.last_idx = 2'd1;
        end
      end
      default: begin
        // unused opcode: drop, no bytes
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_acc <= '0;
    end else if (take) begin
      check_acc <= check_acc_next;
    end
  end

endmodule

// ----- sv/bsfe_queue.sv -----
// ----------------------------------------------------------------------------
// bsfe_queue: short job queue between front and back
// Flip-flop FIFO of job records; lets the front keep accepting while the
// back is still sending bytes of earlier items.
// ----------------------------------------------------------------------------
module bsfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  bsfe_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output bsfe_pkg::job_t rd_job
);
  import bsfe_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == FullCnt);
  assign rd_valid = (count != '0);
  assign rd_job   = store[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/bsfe_back.sv -----
// ----------------------------------------------------------------------------
// bsfe_back: line byte sequencer with output register
// Walks the bytes of the job at the queue head, one per cycle unless a
// held result stalls, into a registered slot the consumer drains with pop.
// ----------------------------------------------------------------------------
module bsfe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  bsfe_pkg::job_t     job,
  output logic               job_done,
  output logic               empty,
  input  logic               pop,
  output bsfe_pkg::out_item_t result
);
  import bsfe_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       at_last;

  assign load     = !out_valid || pop;
  assign at_last  = (idx == job.last_idx);
  assign job_done = load && job_valid && at_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      result.out_byte <= job.bytes[idx];
      result.run_last <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= job_valid;
      if (job_valid) begin
        // advance within the job, rewind once its last byte is out
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ----- sv/byte_stuffing_frame_encoder_core.sv -----
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_core: HDLC-style byte stuffing frame encoder
// Start items open a frame with flag and header, payload bytes are escaped
// where needed, end items close with an escaped inverted XOR check and a flag.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  item     | push / full        | opcode, command, device_id, data_byte
//  result   | pop / empty        | out_byte, run_last
//
//  One line byte leaves per cycle through the output register while the
//  consumer pops, and the back sequencer sets that rate; an item yields one
//  to three bytes (start two, payload byte one or two, end two or three).
//  An item is taken in any cycle the job queue has room, also while results wait.
//  Reset clears the check accumulator, the queue and the output slot.
//  An unused opcode is taken and sends nothing.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bsfe_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output bsfe_pkg::out_item_t result
);
  import bsfe_pkg::*;

  logic q_full;
  logic take;
  logic front_valid;
  job_t front_job;
  logic head_valid;
  job_t head_job;
  logic head_done;

  assign full = q_full;
  assign take = push && !q_full;

  bsfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .job_valid (front_valid),
    .job       (front_job)
  );

  bsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take && front_valid),
    .wr_job   (front_job),
    .full     (q_full),
    .rd_en    (head_done),
    .rd_valid (head_valid),
    .rd_job   (head_job)
  );

  bsfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_done  (head_done),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- sv/bsfe_checker.sv -----
// ----------------------------------------------------------------------------
// bsfe_checker: port-level checks of the frame encoder
// Watches the item and result queues over time; bound to the top level.
// ----------------------------------------------------------------------------
module bsfe_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input bsfe_pkg::out_item_t result
);
  import bsfe_pkg::*;

  // reset leaves nothing to deliver and room for items
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result waiting or queue full after reset");

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while not popped");

  // bytes of one transaction follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.run_last) |=> !empty)
    else $error("gap inside the bytes of one transaction");

  // an escape byte inside a transaction is followed by an escaped flag or escape
  a_escape: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.run_last && result.out_byte == ESC_BYTE) |=>
      (result.out_byte == (FLAG_BYTE ^ ESC_XOR) || result.out_byte == (ESC_BYTE ^ ESC_XOR)))
    else $error("escape byte not followed by a stuffed byte");

endmodule

bind byte_stuffing_frame_encoder_core bsfe_checker u_bsfe_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ----- tb/tb_byte_stuffing_frame_encoder_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stuffing_frame_encoder_core: self-checking bench for the frame encoder
// Drives a short table of directed items, then random frames with escape-heavy
// payloads, broken frames and noise. A predictor tracks the check accumulator,
// and every line byte popped from the block is compared with its expectation.
// ----------------------------------------------------------------------------
module tb_byte_stuffing_frame_encoder_core;
  import bsfe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RandomItems = 460;
  localparam int HoldAtItem = 60;
  localparam int HoldCycles = 80;
  localparam int DrainCycles = 20;
  // Longest quiet spell: receiver hold-off plus unlucky idle runs on both sides.
  localparam int LimitCycles = 3000;

  typedef struct {
    in_item_t         it;
    int               n_typed;   // -1: take the predictor's bytes
    logic [2:0][7:0]  bytes;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  byte_stuffing_frame_encoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  logic [7:0] check_acc;
  out_item_t  line_q[$];
  out_item_t  pred[$];
  stim_row_t  dir_rows[$];

  logic       row_typed;
  out_item_t  row_exp[$];

  int send_idle_pct;
  int pop_idle_pct;
  int items_in;
  int frames_sent;
  int bytes_checked = 0;
  int errors = 0;
  int quiet_cycles = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Push the line bytes of one value, escaping flag and escape bytes.
  function automatic void stuff_byte(input logic [7:0] v, ref out_item_t seq[$]);
    if (v == FLAG_BYTE || v == ESC_BYTE) begin
      seq.push_back('{out_byte: ESC_BYTE, run_last: 1'b0});
      seq.push_back('{out_byte: v ^ ESC_XOR, run_last: 1'b0});
    end else begin
      seq.push_back('{out_byte: v, run_last: 1'b0});
    end
  endfunction

  // Line bytes caused by one transaction; updates the running check.
  function automatic void encode_item(input in_item_t it, ref out_item_t seq[$]);
    logic [7:0] hdr;
    seq = {};
    case (it.opcode)
      OP_START: begin
        hdr = it.command | it.device_id;
        seq.push_back('{out_byte: FLAG_BYTE, run_last: 1'b0});
        seq.push_back('{out_byte: hdr, run_last: 1'b0});
        check_acc = hdr;
      end
      OP_DATA: begin
        stuff_byte(it.data_byte, seq);
        foreach (seq[i]) check_acc = check_acc ^ seq[i].out_byte;
      end
      OP_END: begin
        stuff_byte(~check_acc, seq);
        seq.push_back('{out_byte: FLAG_BYTE, run_last: 1'b0});
      end
      default: ;
    endcase
    if (seq.size() > 0) seq[seq.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [7:0] cmd,
                                  input logic [7:0] dev, input logic [7:0] dat,
                                  input int n, input logic [7:0] b0 = 8'h00,
                                  input logic [7:0] b1 = 8'h00,
                                  input logic [7:0] b2 = 8'h00);
    stim_row_t r;
    r.it = '{opcode: op, command: cmd, device_id: dev, data_byte: dat};
    r.n_typed = n;
    r.bytes = {b2, b1, b0};
    dir_rows.push_back(r);
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] op);
    in_item_t it;
    it.opcode = op;
    it.command = 8'($urandom);
    it.device_id = 8'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(input in_item_t it);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    if (it.opcode != OP_UNUSED) items_in++;
    if (it.opcode == OP_END) frames_sent++;
    do begin
      @(posedge clk);
      took = !full;
      @(negedge clk);
    end while (!took);
  endtask

  task automatic send_random(input in_item_t it);
    row_typed = 1'b0;
    send_item(it);
  endtask

  // Queue expectations on accepted items, check popped line bytes.
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      encode_item(item, pred);
      if (row_typed) pred = row_exp;
      foreach (pred[i]) line_q.push_back(pred[i]);
    end
    if (!rst && pop && !empty) begin
      bytes_checked++;
      if (line_q.size() == 0) begin
        $error("unexpected line byte %02h run_last %0b", result.out_byte, result.run_last);
        errors++;
      end else begin
        if (result.out_byte !== line_q[0].out_byte) begin
          $error("out_byte: expected %02h, got %02h", line_q[0].out_byte, result.out_byte);
          errors++;
        end
        if (result.run_last !== line_q[0].run_last) begin
          $error("run_last: expected %0b, got %0b", line_q[0].run_last, result.run_last);
          errors++;
        end
        void'(line_q.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LimitCycles) begin
      $display("timeout: no transaction for %0d cycles", LimitCycles);
      $display("** byte_stuffing_frame_encoder_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random pop, with one long hold-off so the block fills up.
  initial begin
    logic held;
    held = 1'b0;
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held && items_in >= HoldAtItem) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
      @(negedge clk);
    end
  end

  initial begin
    in_item_t it;
    int nbytes;
    int kind;
    int sent;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    check_acc = 8'h00;
    row_typed = 1'b0;
    send_idle_pct = 23;
    pop_idle_pct = 23;
    items_in = 0;
    frames_sent = 0;

    // End without start sends the inverted empty check.
    add_row(OP_END, 8'h00, 8'h00, 8'h00, 2, 8'hff, FLAG_BYTE);
    add_row(OP_UNUSED, 8'h00, 8'h00, 8'h00, 0);
    add_row(OP_START, 8'h00, 8'h00, 8'h00, 2, FLAG_BYTE, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, FLAG_BYTE, 2, ESC_BYTE, 8'h5e);
    add_row(OP_DATA, 8'h00, 8'h00, ESC_BYTE, 2, ESC_BYTE, 8'h5d);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 1, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'hff, 1, 8'hff);
    add_row(OP_END, 8'h00, 8'h00, 8'h00, -1);
    // Payload after an end keeps folding into the check that the next end sends.
    add_row(OP_DATA, 8'hff, 8'hff, 8'h55, -1);
    add_row(OP_END, 8'hff, 8'hff, 8'hff, -1);
    add_row(OP_START, 8'hff, 8'h00, 8'hff, 2, FLAG_BYTE, 8'hff);
    // Header equal to the flag goes out unescaped.
    add_row(OP_START, FLAG_BYTE, 8'h00, 8'h00, 2, FLAG_BYTE, FLAG_BYTE);
    // Check bytes that land on the flag and on the escape.
    add_row(OP_START, 8'h81, 8'h00, 8'h00, -1);
    add_row(OP_END, 8'h00, 8'h00, 8'h00, 3, ESC_BYTE, 8'h5e, FLAG_BYTE);
    add_row(OP_START, 8'h80, 8'h02, 8'h00, -1);
    add_row(OP_END, 8'h00, 8'h00, 8'h00, 3, ESC_BYTE, 8'h5d, FLAG_BYTE);
    add_row(OP_START, 8'h0f, 8'hf0, 8'h00, 2, FLAG_BYTE, 8'hff);
    add_row(OP_DATA, 8'hff, 8'hff, 8'h12, -1);
    add_row(OP_UNUSED, 8'hff, 8'hff, 8'hff, 0);
    add_row(OP_END, 8'h00, 8'h00, 8'h00, -1);

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      row_typed = (dir_rows[r].n_typed >= 0);
      row_exp = {};
      for (int b = 0; b < dir_rows[r].n_typed; b++)
        row_exp.push_back('{out_byte: dir_rows[r].bytes[b],
                            run_last: (b == dir_rows[r].n_typed - 1)});
      send_item(dir_rows[r].it);
    end

    sent = 0;
    while (sent < RandomItems) begin
      // Run a stretch with no idling on either side.
      if (sent >= 200 && sent < 300) begin
        send_idle_pct = 0;
        pop_idle_pct = 0;
      end else begin
        send_idle_pct = 23;
        pop_idle_pct = 23;
      end
      kind = $urandom_range(9);
      if (kind <= 7) begin
        // Well-formed frame, payload biased toward bytes that need escaping.
        send_random(rand_item(OP_START));
        nbytes = $urandom_range(6);
        for (int i = 0; i < nbytes; i++) begin
          it = rand_item(OP_DATA);
          if ($urandom_range(3) == 0) it.data_byte = $urandom_range(1) ? FLAG_BYTE : ESC_BYTE;
          send_random(it);
        end
        send_random(rand_item(OP_END));
        sent += nbytes + 2;
      end else if (kind == 8) begin
        // Broken frame: payload with no start, or a start that never ends.
        if ($urandom_range(1)) begin
          send_random(rand_item(OP_START));
          sent++;
        end
        nbytes = $urandom_range(1, 3);
        for (int i = 0; i < nbytes; i++) send_random(rand_item(OP_DATA));
        sent += nbytes;
      end else begin
        it = rand_item(2'($urandom_range(3)));
        send_random(it);
        if (it.opcode != OP_UNUSED) sent++;
      end
    end
    push <= 1'b0;

    while (line_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d items in %0d frames incl. escapes, stuffed checks and noise",
             items_in, frames_sent);
    $display("checked %0d line bytes, %0d mismatches", bytes_checked, errors);
    if (errors == 0) begin
      $display("** byte_stuffing_frame_encoder_core: PASSED **");
    end else begin
      $display("** byte_stuffing_frame_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
